/* sv/dtc_pkg.sv */
package dtc_pkg;

    localparam int HEIGHT_W = 4;
    localparam int WIDTH_W  = 11;
    localparam int COUNT_W  = 30;

    localparam logic [COUNT_W-1:0] TILE_MOD = 30'd1000000007;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_GAP,
        ST_FETCH,
        ST_LOAD,
        ST_DONE
    } dtc_state_t;

    // one destination mask per cycle, handed from the sequencer to the adder
    typedef struct packed {
        logic valid;
        logic bank;   // bank being read; the write goes to the other one
        logic use_b;  // second term (vertical domino) contributes
        logic init;   // first cell: table is implicit, entry zero is one
        logic a_one;  // first read address is mask zero
        logic b_one;  // second read address is mask zero
    } dtc_issue_t;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } dtc_result_t;

endpackage

/* sv/domino_tiling_counter_unit.sv */
// channel | dir | payload
// s_*     | in  | tdata[3:0] grid_height, tdata[14:4] grid_width
// m_*     | out | tdata[29:0] tiling_count
//
// A full job sweeps every mask for each of cols * rows cells and then reads mask
// zero; the count is known at once for odd-by-odd or empty grids. The table RAM
// takes one destination mask per cycle (two reads, one write) and each cell ends
// with a gap state so its last write lands before the next cell reads. Reset
// clears the sequencer and the output register; the table RAM needs no clearing.
// s_tready is high only while idle; a held result stalls the next job.
module domino_tiling_counter_unit #(
    parameter int MAX_ROWS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // grid_height[3:0], grid_width[14:4], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // tiling_count[29:0], zero pad
);

    import dtc_pkg::*;

    localparam int MASK_W = MAX_ROWS;
    localparam int DEPTH  = 2 << MAX_ROWS;

    dtc_issue_t         issue;
    dtc_result_t        result;
    logic [MASK_W-1:0]  wr_mask;
    logic [MASK_W:0]    raddr_a;
    logic [MASK_W:0]    raddr_b;
    logic [COUNT_W-1:0] rdata_a;
    logic [COUNT_W-1:0] rdata_b;
    logic               we;
    logic [MASK_W:0]    waddr;
    logic [COUNT_W-1:0] wdata;
    logic               ready;
    logic               start;
    logic               out_free;

    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;

    assign start    = s_tvalid & ready;
    assign s_tready = ready;
    assign out_free = ~out_valid_reg | m_tready;

    dtc_seq #(
        .MAX_ROWS (MAX_ROWS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .grid_height (s_tdata[3:0]),
        .grid_width  (s_tdata[14:4]),
        .ready       (ready),
        .out_free    (out_free),
        .issue       (issue),
        .wr_mask     (wr_mask),
        .raddr_a     (raddr_a),
        .raddr_b     (raddr_b),
        .rdata_a     (rdata_a),
        .result      (result)
    );

    dtc_acc #(
        .MASK_W (MASK_W)
    ) u_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .wr_mask (wr_mask),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata)
    );

    // two banks of 2^MAX_ROWS counts, bank select in the top address bit
    dtc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
        end
        else if (result.valid)
        begin
            out_valid_reg <= 1'b1;
            out_count_reg <= result.count;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_count_reg};

endmodule

/* sv/dtc_ram.sv */
module dtc_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* sv/dtc_acc.sv */
module dtc_acc #(
    parameter int MASK_W = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dtc_pkg::dtc_issue_t           issue,
    input  logic [MASK_W-1:0]             wr_mask,
    input  logic [dtc_pkg::COUNT_W-1:0]   rdata_a,
    input  logic [dtc_pkg::COUNT_W-1:0]   rdata_b,
    output logic                          we,
    output logic [MASK_W:0]               waddr,
    output logic [dtc_pkg::COUNT_W-1:0]   wdata
);

    import dtc_pkg::*;

    dtc_issue_t         issue_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [COUNT_W-1:0] term_a;
    logic [COUNT_W-1:0] term_b;
    logic [COUNT_W:0]   sum;

    // lines up with the registered read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            issue_reg <= issue;
            mask_reg  <= wr_mask;
        end
    end

    always_comb
    begin
        if (issue_reg.init)
        begin
            term_a = COUNT_W'(issue_reg.a_one);
            term_b = COUNT_W'(issue_reg.b_one);
        end
        else
        begin
            term_a = rdata_a;
            term_b = rdata_b;
        end
        if (!issue_reg.use_b)
        begin
            term_b = '0;
        end
        sum = {1'b0, term_a} + {1'b0, term_b};
    end

    assign we    = issue_reg.valid;
    assign waddr = {~issue_reg.bank, mask_reg};
    assign wdata = (sum >= {1'b0, TILE_MOD}) ? COUNT_W'(sum - {1'b0, TILE_MOD})
                                              : COUNT_W'(sum);

endmodule

/* sv/dtc_seq.sv */
module dtc_seq #(
    parameter int MAX_ROWS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dtc_pkg::HEIGHT_W-1:0]  grid_height,
    input  logic [dtc_pkg::WIDTH_W-1:0]   grid_width,
    output logic                          ready,
    input  logic                          out_free,
    output dtc_pkg::dtc_issue_t           issue,
    output logic [MAX_ROWS-1:0]           wr_mask,
    output logic [MAX_ROWS:0]             raddr_a,
    output logic [MAX_ROWS:0]             raddr_b,
    input  logic [dtc_pkg::COUNT_W-1:0]   rdata_a,
    output dtc_pkg::dtc_result_t          result
);

    import dtc_pkg::*;

    localparam int MASK_W = MAX_ROWS;
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int MW1    = MAX_ROWS + 1;

    dtc_state_t state_reg, state_next;

    logic [ROW_W-1:0]   rows_reg, rows_next;
    logic [WIDTH_W-1:0] cols_reg, cols_next;
    logic [MASK_W-1:0]  mask_last_reg, mask_last_next;
    logic [MASK_W-1:0]  d_reg, d_next;
    logic [ROW_W-1:0]   r_reg, r_next;
    logic [WIDTH_W-1:0] c_reg, c_next;
    logic               bank_reg, bank_next;
    logic               first_reg, first_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [4:0]         height_ext;
    logic [4:0]         rows_clamp;
    logic [ROW_W-1:0]   rows_eff;
    logic [MW1-1:0]     masks_eff;
    logic               odd_odd;
    logic               empty_grid;
    logic               last_mask;
    logic               last_row;
    logic               last_col;
    logic [MASK_W-1:0]  bit_sel;
    logic [MASK_W-1:0]  below_sel;
    logic [MASK_W-1:0]  mask_a;
    logic [MASK_W-1:0]  mask_b;
    logic               use_b;

    assign height_ext = {1'b0, grid_height};
    assign rows_clamp = (height_ext > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : height_ext;
    assign rows_eff   = ROW_W'(rows_clamp);
    assign masks_eff  = MW1'(1) << rows_eff;
    assign odd_odd    = rows_clamp[0] & grid_width[0];
    assign empty_grid = (rows_clamp == 5'd0) || (grid_width == '0);

    assign last_mask = (d_reg == mask_last_reg);
    assign last_row  = (r_reg == rows_reg - ROW_W'(1));
    assign last_col  = (c_reg == cols_reg - WIDTH_W'(1));

    // pull form: next[d] = cur[d ^ bit] + (bit clear, below set ? cur[d ^ below] : 0)
    assign bit_sel   = MASK_W'(1) << r_reg;
    assign below_sel = bit_sel << 1;
    assign mask_a    = d_reg ^ bit_sel;
    assign mask_b    = d_reg ^ below_sel;
    assign use_b     = ~|(d_reg & bit_sel) & |(d_reg & below_sel);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (odd_odd || empty_grid) ? ST_DONE : ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (last_mask)
                begin
                    state_next = ST_GAP;
                end
            end
            ST_GAP:
            begin
                state_next = (last_row && last_col) ? ST_FETCH : ST_SWEEP;
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ready        = 1'b0;
        issue        = '0;
        raddr_a      = {bank_reg, mask_a};
        raddr_b      = {bank_reg, mask_b};
        result.valid = 1'b0;
        result.count = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
            end
            ST_SWEEP:
            begin
                issue.valid = 1'b1;
                issue.bank  = bank_reg;
                issue.use_b = use_b;
                issue.init  = first_reg;
                issue.a_one = (mask_a == '0);
                issue.b_one = (mask_b == '0);
            end
            ST_FETCH:
            begin
                raddr_a = {bank_reg, {MASK_W{1'b0}}};
            end
            ST_DONE:
            begin
                result.valid = out_free;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

    assign wr_mask = d_reg;

    always_comb
    begin
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        mask_last_next = mask_last_reg;
        d_next         = d_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        bank_next      = bank_reg;
        first_next     = first_reg;
        count_next     = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rows_next      = rows_eff;
                    cols_next      = grid_width;
                    mask_last_next = MASK_W'(masks_eff - MW1'(1));
                    d_next         = '0;
                    r_next         = '0;
                    c_next         = '0;
                    bank_next      = 1'b0;
                    first_next     = 1'b1;
                    count_next     = odd_odd ? '0 : COUNT_W'(1);
                end
            end
            ST_SWEEP:
            begin
                if (!last_mask)
                begin
                    d_next = d_reg + MASK_W'(1);
                end
            end
            ST_GAP:
            begin
                d_next     = '0;
                bank_next  = ~bank_reg;
                first_next = 1'b0;
                if (last_row)
                begin
                    r_next = '0;
                    c_next = c_reg + WIDTH_W'(1);
                end
                else
                begin
                    r_next = r_reg + ROW_W'(1);
                end
            end
            ST_LOAD:
            begin
                count_next = rdata_a;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rows_reg      <= '0;
            cols_reg      <= '0;
            mask_last_reg <= '0;
            d_reg         <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            bank_reg      <= 1'b0;
            first_reg     <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            mask_last_reg <= mask_last_next;
            d_reg         <= d_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            bank_reg      <= bank_next;
            first_reg     <= first_next;
            count_reg     <= count_next;
        end
    end

    a_mask_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> d_reg <= mask_last_reg)
        else $error("mask counter past last mask");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> r_reg < rows_reg)
        else $error("row counter past grid height");

    a_gap_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GAP |=> state_reg == ST_SWEEP || state_reg == ST_FETCH)
        else $error("bad exit from cell gap");

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;

    import dtc_pkg::*;

    localparam int          MAX_ROWS    = 10;
    localparam int          TABLE_DEPTH = 1 << MAX_ROWS;
    localparam int unsigned MOD_P       = 32'(TILE_MOD);
    localparam int          NUM_RANDOM  = 100;
    localparam int          NUM_DIRECT  = 20;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [WIDTH_W-1:0]  width;
        logic                known;   // count typed in below, else predicted
        logic [COUNT_W-1:0]  count;
    } tiling_job_t;

    typedef struct {
        logic [HEIGHT_W-1:0] height;
        logic [WIDTH_W-1:0]  width;
        logic [COUNT_W-1:0]  count;
    } tiling_expect_t;

    // kept cheap: a full 10-row grid sweeps every mask once per row of each column
    localparam tiling_job_t DIRECTED_JOBS [0:NUM_DIRECT-1] = '{
        '{4'd0,  11'd0,    1'b1, 30'd1},   // empty grid
        '{4'd0,  11'd2047, 1'b1, 30'd1},   // zero height, widest field
        '{4'd5,  11'd0,    1'b1, 30'd1},   // zero width
        '{4'd1,  11'd1,    1'b1, 30'd0},   // both odd
        '{4'd9,  11'd2047, 1'b1, 30'd0},   // both odd, widest
        '{4'd3,  11'd2047, 1'b1, 30'd0},
        '{4'd15, 11'd1,    1'b1, 30'd1},   // clamped to 10 rows before odd test
        '{4'd11, 11'd1,    1'b1, 30'd1},
        '{4'd12, 11'd2,    1'b0, 30'd0},
        '{4'd1,  11'd2,    1'b1, 30'd1},
        '{4'd1,  11'd2046, 1'b1, 30'd1},
        '{4'd2,  11'd2,    1'b1, 30'd2},
        '{4'd3,  11'd2,    1'b1, 30'd3},
        '{4'd4,  11'd4,    1'b1, 30'd36},
        '{4'd4,  11'd1,    1'b1, 30'd1},
        '{4'd2,  11'd1024, 1'b0, 30'd0},   // wraps the modulus
        '{4'd10, 11'd3,    1'b0, 30'd0},
        '{4'd8,  11'd8,    1'b0, 30'd0},
        '{4'd7,  11'd6,    1'b0, 30'd0},
        '{4'd6,  11'd7,    1'b0, 30'd0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    tiling_expect_t pending_counts[$];
    int             error_count;
    int             sender_idle_pct;
    int             recv_stall_pct;
    int             hold_request;

    domino_tiling_counter_unit #(
        .MAX_ROWS (MAX_ROWS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned add_mod(input int unsigned a, input int unsigned b);
        int unsigned s;
        s = a + b;
        return (s >= MOD_P) ? s - MOD_P : s;
    endfunction

    // broken-profile DP: one mask bit per row, set when that cell is already covered
    function automatic logic [COUNT_W-1:0] count_tilings(input logic [HEIGHT_W-1:0] height,
                                                         input logic [WIDTH_W-1:0] width);
        int unsigned cur [TABLE_DEPTH];
        int unsigned nxt [TABLE_DEPTH];
        int unsigned v;
        int          rows;
        int          n_masks;
        rows = (height > MAX_ROWS) ? MAX_ROWS : int'(height);
        if (rows[0] && width[0])
            return '0;
        n_masks = 1 << rows;
        for (int m = 0; m < n_masks; m++)
            cur[m] = 0;
        cur[0] = 1;
        for (int c = 0; c < int'(width); c++)
        begin
            for (int r = 0; r < rows; r++)
            begin
                for (int m = 0; m < n_masks; m++)
                    nxt[m] = 0;
                for (int m = 0; m < n_masks; m++)
                begin
                    v = cur[m];
                    if (v != 0)
                    begin
                        if ((m >> r) & 1)
                            nxt[m & ~(1 << r)] = add_mod(nxt[m & ~(1 << r)], v);
                        else
                        begin
                            nxt[m | (1 << r)] = add_mod(nxt[m | (1 << r)], v);
                            if (r + 1 < rows && !((m >> (r + 1)) & 1))
                                nxt[m | (1 << (r + 1))] = add_mod(nxt[m | (1 << (r + 1))], v);
                        end
                    end
                end
                for (int m = 0; m < n_masks; m++)
                    cur[m] = nxt[m];
            end
        end
        return cur[0][COUNT_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // offer one item; valid stays high on return so back-to-back items need no gap
    task automatic send_job(input logic [HEIGHT_W-1:0] height, input logic [WIDTH_W-1:0] width,
                            input logic known, input logic [COUNT_W-1:0] count);
        tiling_expect_t e;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, width, height};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        e.height = height;
        e.width  = width;
        e.count  = known ? count : count_tilings(height, width);
        pending_counts.push_back(e);
    endtask

    task automatic wait_all_done();
        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_job();
        logic [HEIGHT_W-1:0] h;
        logic [WIDTH_W-1:0]  w;
        int                  sel;
        sel = $urandom_range(99);
        if (sel < 20)
        begin
            // tall grids: few columns, except odd-by-odd which is instant
            h = HEIGHT_W'($urandom_range(15, 8));
            w = WIDTH_W'($urandom_range(2));
            if (h == 4'd9 && $urandom_range(1))
                w = WIDTH_W'($urandom_range(2047)) | 11'd1;
        end
        else if (sel < 35)
        begin
            h = HEIGHT_W'($urandom_range(2));
            w = WIDTH_W'($urandom_range(2047));
        end
        else
        begin
            h = HEIGHT_W'($urandom_range(7));
            w = WIDTH_W'($urandom_range(15));
        end
        send_job(h, w, 1'b0, '0);
    endtask

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_counts.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d", m_tdata[COUNT_W-1:0]));
                else
                begin
                    tiling_expect_t e;
                    e = pending_counts.pop_front();
                    if (m_tdata[COUNT_W-1:0] !== e.count)
                        report_mismatch($sformatf("%0dx%0d: tiling_count %0d, want %0d",
                                                  e.height, e.width, m_tdata[COUNT_W-1:0],
                                                  e.count));
                end
            end
            if (hold_left == 0 && hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #100ms;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int sender_pcts [4];
        int recv_pcts   [4];
        sender_pcts = '{0, 76, 0, 35};
        recv_pcts   = '{0, 0, 76, 35};
        clk             = 1'b0;
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        error_count     = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_request    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_JOBS[i])
            send_job(DIRECTED_JOBS[i].height, DIRECTED_JOBS[i].width,
                     DIRECTED_JOBS[i].known, DIRECTED_JOBS[i].count);
        wait_all_done();

        // result held back long enough that small jobs back up into the input
        hold_request = 400;
        for (int i = 0; i < 4; i++)
            send_job(HEIGHT_W'($urandom_range(3)), WIDTH_W'($urandom_range(7)), 1'b0, '0);
        wait_all_done();

        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct = sender_pcts[p];
            recv_stall_pct  = recv_pcts[p];
            for (int i = 0; i < NUM_RANDOM / 4; i++)
                send_random_job();
            wait_all_done();
        end

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
